[rtl/hcbp_pkg.sv]
// ---------------------------------------------------------------------------
// hcbp_pkg
// Opcodes and fixed constants of the Huffman code bit packer.
// ---------------------------------------------------------------------------
package hcbp_pkg;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_LOAD   = 2'd0;
	localparam opcode_t OP_ENCODE = 2'd1;
	localparam opcode_t OP_FLUSH  = 2'd2;

	localparam int BYTE_BITS     = 8;
	localparam int IN_DATA_W     = 48;
	localparam int VALUE_W       = 32;

endpackage
// ---------------------------------------------------------------------------

[rtl/huffman_code_bit_packer.sv]
// ---------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman encoder that packs codes MSB first into bytes.
// ---------------------------------------------------------------------------
// An encode request reads the code table in its accept cycle; its first byte
// passes the table read register and then the output byte register, a flush
// byte the request stage and then the output byte register. Throughput: one
// request per cycle while each yields at most one byte and the output is free;
// a request with more bytes holds the next one back until its bytes are out.
// Reset clears the bit accumulator and all handshake state; code table
// entries are undefined until loaded.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// symbol[7:0], code_length[13:8], code_value[45:14], zero
	input  logic [hcbp_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,  // opcode[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,  // out_byte[7:0]
	output logic                             m_tlast,  // last_of_item
	output logic                             m_tuser   // end_of_stream[0]
);

	localparam int AW      = $clog2(SYMBOL_COUNT);
	localparam int LW      = $clog2(MAX_CODE_LEN + 1);
	localparam int ENTRY_W = LW + MAX_CODE_LEN;
	localparam int ACC_W   = MAX_CODE_LEN + hcbp_pkg::BYTE_BITS;
	localparam int CW      = $clog2(ACC_W + 1);

	hcbp_pkg::opcode_t                opcode;
	logic [7:0]                       symbol;
	logic [5:0]                       code_length;
	logic [hcbp_pkg::VALUE_W-1:0]     code_value;
	logic                     accept;
	logic                     in_range;
	logic [LW-1:0]            len_sat;
	logic [MAX_CODE_LEN-1:0]  bits_masked;
	logic [ENTRY_W-1:0]       rd_data;

	logic                     valid_s1;
	logic                     flush_s1;
	logic                     inrange_s1;

	logic [ACC_W-1:0]         acc_q;
	logic [CW-1:0]            cnt_q;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic                     out_last_q;
	logic                     out_eos_q;

	logic                     busy;
	logic                     out_free;
	logic                     absorb;
	logic                     flush_go;
	logic                     adv_s1;
	logic                     emit;
	logic [LW-1:0]            clen;
	logic [MAX_CODE_LEN-1:0]  cbits;
	logic [ACC_W-1:0]         src_acc;
	logic [CW-1:0]            src_cnt;
	logic [CW-1:0]            rest_cnt;
	logic [7:0]               emit_byte;
	logic [ACC_W-1:0]         rest_acc;

	assign opcode      = s_tuser;
	assign symbol      = s_tdata[7:0];
	assign code_length = s_tdata[13:8];
	assign code_value  = s_tdata[45:14];
	assign accept      = s_tvalid && s_tready;
	assign in_range    = {1'b0, symbol} < 9'(SYMBOL_COUNT);

	always_comb begin
		logic [63:0] v64;
		v64 = {32'b0, code_value};
		if (code_length > 6'(MAX_CODE_LEN)) begin
			len_sat = LW'(MAX_CODE_LEN);
		end else begin
			len_sat = LW'(code_length);
		end
		for (int i = 0; i < MAX_CODE_LEN; i++) begin
			bits_masked[i] = v64[i] && (i < int'(len_sat));
		end
	end

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_code_table (
		.clk   (clk),
		.we    (accept && opcode == hcbp_pkg::OP_LOAD && in_range),
		.waddr (symbol[AW-1:0]),
		.wdata ({len_sat, bits_masked}),
		.re    (accept && opcode == hcbp_pkg::OP_ENCODE),
		.raddr (symbol[AW-1:0]),
		.rdata (rd_data)
	);

	assign busy     = cnt_q > CW'(hcbp_pkg::BYTE_BITS);
	assign out_free = !out_valid_q || m_tready;
	assign absorb   = valid_s1 && !flush_s1 && !busy;
	assign flush_go = valid_s1 && flush_s1 && !busy && out_free;
	assign adv_s1   = absorb || flush_go;
	assign s_tready = !valid_s1 || adv_s1;

	assign clen  = inrange_s1 ? rd_data[ENTRY_W-1:MAX_CODE_LEN] : '0;
	assign cbits = inrange_s1 ? rd_data[MAX_CODE_LEN-1:0] : '0;

	always_comb begin
		if (absorb) begin
			src_acc = (acc_q << clen) | ACC_W'(cbits);
			src_cnt = cnt_q + CW'(clen);
		end else begin
			src_acc = acc_q;
			src_cnt = cnt_q;
		end
		emit      = (src_cnt > CW'(hcbp_pkg::BYTE_BITS)) && out_free;
		rest_cnt  = src_cnt - CW'(hcbp_pkg::BYTE_BITS);
		emit_byte = 8'(src_acc >> rest_cnt);
		for (int i = 0; i < ACC_W; i++) begin
			rest_acc[i] = src_acc[i] && (i < int'(rest_cnt));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && (opcode == hcbp_pkg::OP_ENCODE ||
				opcode == hcbp_pkg::OP_FLUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1   <= opcode == hcbp_pkg::OP_FLUSH;
			inrange_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (flush_go) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (emit) begin
			acc_q <= rest_acc;
			cnt_q <= rest_cnt;
		end else begin
			acc_q <= src_acc;
			cnt_q <= src_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit || flush_go;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_go) begin
			out_byte_q <= acc_q[7:0];
			out_last_q <= 1'b1;
			out_eos_q  <= 1'b1;
		end else if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= (rest_cnt <= CW'(hcbp_pkg::BYTE_BITS));
			out_eos_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_eos_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ACC_W))
		else $error("bit accumulator count exceeds its capacity");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy && valid_s1 |-> !s_tready)
		else $error("new request taken while bytes of the previous one are owed");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_go |=> cnt_q == '0 && m_tvalid && m_tuser)
		else $error("flush did not clear the accumulator or present its byte");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("flushed byte not marked as last of its request");

endmodule
// ---------------------------------------------------------------------------

[rtl/hcbp_ram.sv]
// ---------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
// ---------------------------------------------------------------------------

[sim/tb_huffman_code_bit_packer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_huffman_code_bit_packer
// Streams load, encode and flush requests into the bit packer and checks
// every emitted byte. The checker keeps its own code table and bit
// accumulator and derives each expected byte, with its end-of-request and
// end-of-stream flags, from the requests the block accepts. The sender
// works in bursts with random gaps and the receiver stalls on a pattern
// of its own.
// ---------------------------------------------------------------------------
module tb_huffman_code_bit_packer;

	localparam int                CODE_LEN_LIMIT = 32;
	localparam hcbp_pkg::opcode_t OP_UNUSED      = 2'd3;
	localparam int                RANDOM_ITEMS   = 78;
	localparam int                WATCHDOG_LIMIT = 2000;
	localparam int                DRAIN_CYCLES   = 20;

	typedef struct {
		bit [7:0] data;
		bit       last;
		bit       eos;
	} packed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	huffman_code_bit_packer #(
		.SYMBOL_COUNT(256),
		.MAX_CODE_LEN(CODE_LEN_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	class ByteScoreboard;
		bit [5:0]     code_len [256];
		bit [63:0]    code_bits [256];
		bit [63:0]    acc_bits;
		int unsigned  acc_count;
		packed_byte_t expected_bytes [$];
		int           errors;

		function bit [63:0] low_mask(int unsigned n);
			if (n >= 64)
				return ~64'd0;
			return (64'd1 << n) - 64'd1;
		endfunction

		function void note_request(hcbp_pkg::opcode_t op, bit [7:0] sym,
				bit [5:0] len, bit [31:0] val);
			int unsigned  clen;
			packed_byte_t b;
			case (op)
			hcbp_pkg::OP_LOAD: begin
				clen = (len > CODE_LEN_LIMIT) ? CODE_LEN_LIMIT : 32'(len);
				code_len[sym] = 6'(clen);
				code_bits[sym] = {32'd0, val} & low_mask(clen);
			end
			hcbp_pkg::OP_ENCODE: begin
				clen = 32'(code_len[sym]);
				if (clen > 0) begin
					acc_bits = ((acc_bits << clen) | code_bits[sym])
						& low_mask(acc_count + clen);
					acc_count += clen;
				end
				while (acc_count > hcbp_pkg::BYTE_BITS) begin
					acc_count -= hcbp_pkg::BYTE_BITS;
					b.data = 8'(acc_bits >> acc_count);
					b.last = (acc_count <= hcbp_pkg::BYTE_BITS);
					b.eos = 1'b0;
					acc_bits &= low_mask(acc_count);
					expected_bytes.push_back(b);
				end
			end
			hcbp_pkg::OP_FLUSH: begin
				b.data = acc_bits[7:0];
				b.last = 1'b1;
				b.eos = 1'b1;
				expected_bytes.push_back(b);
				acc_bits = 64'd0;
				acc_count = 0;
			end
			default: begin
			end
			endcase
		endfunction

		function void check_byte(bit [7:0] data, bit last, bit eos);
			packed_byte_t b;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %02h last %0d eos %0d",
					$time, data, last, eos);
				errors++;
				return;
			end
			b = expected_bytes.pop_front();
			if (b.data != data) begin
				$display("%0t: byte mismatch: expected %02h, actual %02h",
					$time, b.data, data);
				errors++;
			end
			if (b.last != last) begin
				$display("%0t: tlast mismatch: expected %0d, actual %0d",
					$time, b.last, last);
				errors++;
			end
			if (b.eos != eos) begin
				$display("%0t: tuser mismatch: expected %0d, actual %0d",
					$time, b.eos, eos);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	ByteScoreboard sb;
	int            burst_left;
	int            loaded_syms [$];
	bit            loaded [256];
	int            ready_left;
	int            stall_left;
	int            idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_request(hcbp_pkg::opcode_t op, bit [7:0] sym, bit [5:0] len,
			bit [31:0] val);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_tuser = op;
		s_tdata = {2'b00, val, len, sym};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(op, sym, len, val);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic load_entry(bit [7:0] sym, bit [5:0] len, bit [31:0] val);
		send_request(hcbp_pkg::OP_LOAD, sym, len, val);
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(int'(sym));
		end
	endtask

	task automatic encode_symbol(bit [7:0] sym);
		send_request(hcbp_pkg::OP_ENCODE, sym, 6'($urandom), $urandom);
	endtask

	task automatic flush_stream();
		send_request(hcbp_pkg::OP_FLUSH, 8'($urandom), 6'($urandom), $urandom);
	endtask

	function automatic bit [5:0] pick_code_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 6'($urandom_range(1, 10));
		if (r < 90)
			return 6'($urandom_range(11, 32));
		if (r < 97)
			return 6'($urandom_range(33, 63));
		return 6'd0;
	endfunction

	always @(negedge clk) begin
		if (ready_left > 0) begin
			m_tready = 1'b1;
			ready_left--;
		end else if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			ready_left = $urandom_range(1, 20);
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tlast, m_tuser);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int r;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = hcbp_pkg::OP_LOAD;
		m_tready = 1'b0;
		burst_left = 0;
		ready_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		flush_stream();
		load_entry(8'd0, 6'd0, 32'hFFFF_FFFF);
		load_entry(8'd255, 6'd32, 32'hFFFF_FFFF);
		load_entry(8'd1, 6'd63, 32'h8000_0001);
		load_entry(8'd2, 6'd1, 32'h0000_0001);
		load_entry(8'd3, 6'd8, 32'hFFFF_FFA5);
		load_entry(8'd4, 6'd5, 32'hFFFF_FFFF);
		load_entry(8'd5, 6'd40, 32'h1234_5678);
		encode_symbol(8'd0);
		encode_symbol(8'd255);
		encode_symbol(8'd255);
		encode_symbol(8'd2);
		encode_symbol(8'd3);
		encode_symbol(8'd4);
		encode_symbol(8'd1);
		encode_symbol(8'd5);
		send_request(OP_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
		encode_symbol(8'd0);
		flush_stream();
		flush_stream();
		encode_symbol(8'd2);
		flush_stream();
		load_entry(8'd0, 6'd0, 32'd0);

		repeat (RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				load_entry(8'($urandom), pick_code_length(), $urandom);
			else if (r < 82)
				encode_symbol(8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
			else if (r < 93)
				flush_stream();
			else
				send_request(OP_UNUSED, 8'($urandom), 6'($urandom), $urandom);
		end
		flush_stream();
		s_tvalid = 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/hcbp_pkg.sv
rtl/hcbp_ram.sv
rtl/huffman_code_bit_packer.sv
sim/tb_huffman_code_bit_packer.sv
